// ----- src/efd_pkg.sv -----
// Shared types and constants for the escaped frame decoder.
// No dependencies; every module of the block imports this package, the interfaces do not.
package efd_pkg;

    // Escape byte and the control codes that may follow it
    localparam logic [7:0] ESC_BYTE   = 8'h55;
    localparam logic [7:0] MARK_START = 8'h01;
    localparam logic [7:0] MARK_LIT   = 8'h02;
    localparam logic [7:0] MARK_END   = 8'h03;

    // Reset value of the frame length limit
    localparam logic [15:0] MAX_FRAME_RST = 16'd256;

    // End-of-frame status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CSUM  = 2'd1,
        ST_OVF   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // One result item
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        frame_end;
        t_status     status;
        logic [15:0] frame_length;
    } t_result;

endpackage

// ----- src/efd_rx_if.sv -----
// Input channel of the escaped frame decoder: one raw received byte per item.
// Depends on nothing.
interface efd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- src/efd_res_if.sv -----
// Result channel of the escaped frame decoder: payload bytes and end reports.
// Depends on nothing.
interface efd_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [1:0]  status;
    logic [15:0] frame_length;

    modport source (output valid, output data_byte, output frame_end,
                    output status, output frame_length, input ready);
    modport sink   (input valid, input data_byte, input frame_end,
                    input status, input frame_length, output ready);
endinterface

// ----- src/efd_in_stage.sv -----
// Input register of the escaped frame decoder.
// Depends on efd_pkg (house convention; no types needed here).
module efd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_step,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    import efd_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    // Free slot, or the held item moves on this cycle
    assign o_ready = !r_valid || i_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_step) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

// ----- src/efd_decode.sv -----
// Unstuffing, framing and checksum state of the escaped frame decoder.
// Depends on efd_pkg for codes and the result type.
module efd_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic [15:0]      i_max_frame,
    output logic             o_has_res,
    output efd_pkg::t_result o_res
);
    import efd_pkg::*;

    logic        r_in_frame, n_in_frame;
    logic        r_esc, n_esc;
    logic        r_have_held, n_have_held;
    logic [7:0]  r_held, n_held;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_count, n_count;

    // Next state and result for the item in the input register
    always_comb begin
        logic       store;
        logic [7:0] sbyte;
        n_in_frame  = r_in_frame;
        n_esc       = r_esc;
        n_have_held = r_have_held;
        n_held      = r_held;
        n_sum       = r_sum;
        n_count     = r_count;
        o_has_res   = 1'b0;
        o_res       = '{data_byte: 8'h00, frame_end: 1'b0, status: ST_OK,
                        frame_length: 16'h0000};
        store       = 1'b0;
        sbyte       = i_byte;

        if (!r_esc) begin
            if (i_byte == ESC_BYTE) begin
                n_esc = 1'b1;
            end else begin
                store = r_in_frame;
            end
        end else begin
            n_esc = 1'b0;
            if (i_byte == MARK_START) begin
                n_in_frame  = 1'b1;
                n_have_held = 1'b0;
                n_held      = 8'h00;
                n_sum       = 8'h00;
                n_count     = 16'h0000;
            end else if (r_in_frame) begin
                if (i_byte == MARK_END) begin
                    // end marker: report and go back to hunting
                    o_has_res       = 1'b1;
                    o_res.frame_end = 1'b1;
                    if (r_count == 16'h0000) begin
                        o_res.status = ST_EMPTY;
                    end else begin
                        o_res.status       = (r_sum == r_held) ? ST_OK : ST_CSUM;
                        o_res.frame_length = r_count - 16'd1;
                    end
                    n_in_frame  = 1'b0;
                    n_have_held = 1'b0;
                    n_held      = 8'h00;
                    n_sum       = 8'h00;
                    n_count     = 16'h0000;
                end else begin
                    store = 1'b1;
                    if (i_byte == MARK_LIT) begin
                        sbyte = ESC_BYTE;
                    end
                end
            end
        end

        // Store with one-byte hold-back, or abort on overflow
        if (store) begin
            if (r_count >= i_max_frame) begin
                o_has_res       = 1'b1;
                o_res.frame_end = 1'b1;
                o_res.status    = ST_OVF;
                n_in_frame      = 1'b0;
                n_have_held     = 1'b0;
                n_held          = 8'h00;
                n_sum           = 8'h00;
                n_count         = 16'h0000;
            end else begin
                if (r_have_held) begin
                    o_has_res       = 1'b1;
                    o_res.data_byte = r_held;
                    n_sum           = r_sum + r_held;
                end
                n_held      = sbyte;
                n_have_held = 1'b1;
                n_count     = r_count + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_esc       <= 1'b0;
            r_have_held <= 1'b0;
            r_held      <= 8'h00;
            r_sum       <= 8'h00;
            r_count     <= 16'h0000;
        end else if (i_step) begin
            r_in_frame  <= n_in_frame;
            r_esc       <= n_esc;
            r_have_held <= n_have_held;
            r_held      <= n_held;
            r_sum       <= n_sum;
            r_count     <= n_count;
        end
    end
endmodule

// ----- src/efd_out_stage.sv -----
// Result register of the escaped frame decoder.
// Depends on efd_pkg for the result type.
module efd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_has_res,
    input  efd_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output efd_pkg::t_result o_res
);
    import efd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Loaded on every step; a step is only taken when the slot is free or drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step) begin
            r_valid <= i_has_res;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

// ----- src/escaped_frame_decoder.sv -----
// Escaped frame decoder with additive checksum: top level.
// Depends on efd_pkg, efd_rx_if, efd_res_if, efd_in_stage, efd_decode, efd_out_stage.
//
// Usage:
//   i_rx carries one raw byte per item (valid/ready). o_res carries one result
//   item: a payload byte (frame_end 0) or an end report with status and length
//   (frame_end 1). Many input items give no result (escapes, start markers, the
//   held-back checksum, bytes outside a frame).
//   i_cfg_we / i_cfg_data write the frame length limit (reset 256); write it
//   only while the block is idle.
// Timing:
//   One input item per cycle while o_res is not held off. An accepted item is
//   registered in the input register; the decode step then moves its result,
//   if it has one, into the result register, which drives o_res.
//   The decode step from input register to result register is the only state
//   update path.
// Reset:
//   Synchronous, active low: the decoder hunts for a start marker, both
//   registers are empty and the limit returns to 256.
// Stall:
//   While o_res is held off the result register keeps its item, the input
//   register fills and i_rx.ready drops; no item is lost.
module escaped_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    efd_rx_if.sink      i_rx,
    efd_res_if.source   o_res
);
    import efd_pkg::*;

    logic [15:0] r_max;
    logic        in_valid;
    logic [7:0]  in_byte;
    logic        step;
    logic        has_res;
    logic        out_valid;
    t_result     dec_res;
    t_result     out_res;

    // Frame length limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_FRAME_RST;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_data;
        end
    end

    // Item leaves the input register when the result slot is free or drains
    assign step = in_valid && (!out_valid || o_res.ready);

    efd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .i_byte  (i_rx.rx_byte),
        .i_step  (step),
        .o_ready (i_rx.ready),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    efd_decode u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_byte),
        .i_max_frame (r_max),
        .o_has_res   (has_res),
        .o_res       (dec_res)
    );

    efd_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_has_res (has_res),
        .i_res     (dec_res),
        .i_ready   (o_res.ready),
        .o_valid   (out_valid),
        .o_res     (out_res)
    );

    // Result channel
    assign o_res.valid        = out_valid;
    assign o_res.data_byte    = out_res.data_byte;
    assign o_res.frame_end    = out_res.frame_end;
    assign o_res.status       = out_res.status;
    assign o_res.frame_length = out_res.frame_length;
endmodule

// ----- tb/escaped_frame_decoder_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the escaped frame decoder: follows the accepted input bytes and
// limit writes, predicts every result item and compares it with the output channel.
// Depends on efd_pkg, efd_rx_if and efd_res_if.
module escaped_frame_decoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    efd_rx_if           i_rx,
    efd_res_if          i_res,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_frames
);
    import efd_pkg::*;

    // Own copy of the decoder state
    logic [15:0] frame_limit;
    logic        in_frame;
    logic        esc_pending;
    logic        have_held;
    logic [7:0]  held_byte;
    logic [7:0]  payload_sum;
    logic [15:0] stored_count;

    t_result expected_q[$];
    int      fail_count;
    int      checked;
    int      frames;

    // Queue an end report and go back to hunting for a start
    function automatic void push_end(t_status st, logic [15:0] len);
        t_result r;
        r.data_byte    = 8'h00;
        r.frame_end    = 1'b1;
        r.status       = st;
        r.frame_length = len;
        expected_q.push_back(r);
        in_frame     = 1'b0;
        have_held    = 1'b0;
        held_byte    = 8'h00;
        payload_sum  = 8'h00;
        stored_count = 16'd0;
    endfunction

    // Store one unescaped byte; the previously held one becomes payload (overflow at the limit ends the frame)
    function automatic void store_byte(logic [7:0] b);
        t_result r;
        if (stored_count >= frame_limit) begin
            push_end(ST_OVF, 16'd0);
        end else begin
            if (have_held) begin
                r.data_byte    = held_byte;
                r.frame_end    = 1'b0;
                r.status       = ST_OK;
                r.frame_length = 16'd0;
                expected_q.push_back(r);
                payload_sum = payload_sum + held_byte;
            end
            held_byte    = b;
            have_held    = 1'b1;
            stored_count = stored_count + 16'd1;
        end
    endfunction

    // One received byte through the unstuffing state machine
    function automatic void decode_byte(logic [7:0] b);
        if (!esc_pending) begin
            if (b == ESC_BYTE) begin
                esc_pending = 1'b1;
            end else if (in_frame) begin
                store_byte(b);
            end
        end else begin
            esc_pending = 1'b0;
            if (b == MARK_START) begin
                // start, or restart dropping whatever was held
                in_frame     = 1'b1;
                have_held    = 1'b0;
                held_byte    = 8'h00;
                payload_sum  = 8'h00;
                stored_count = 16'd0;
            end else if (in_frame) begin
                if (b == MARK_END) begin
                    if (stored_count == 16'd0) begin
                        push_end(ST_EMPTY, 16'd0);
                    end else begin
                        push_end((payload_sum == held_byte) ? ST_OK : ST_CSUM,
                                 stored_count - 16'd1);
                    end
                end else begin
                    store_byte((b == MARK_LIT) ? ESC_BYTE : b);
                end
            end
        end
    endfunction

    // Compare outputs first: a result never stems from an item taken at the same edge
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            frame_limit  = MAX_FRAME_RST;
            in_frame     = 1'b0;
            esc_pending  = 1'b0;
            have_held    = 1'b0;
            held_byte    = 8'h00;
            payload_sum  = 8'h00;
            stored_count = 16'd0;
            expected_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.data_byte    = i_res.data_byte;
                got.frame_end    = i_res.frame_end;
                got.status       = t_status'(i_res.status);
                got.frame_length = i_res.frame_length;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result: byte %02h end %0d status %0d length %0d",
                             $time, got.data_byte, got.frame_end, got.status,
                             got.frame_length);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (want.frame_end) frames++;
                    if (got !== want) begin
                        $display({"%0t: expected byte %02h end %0d status %0d length %0d,",
                                  " got byte %02h end %0d status %0d length %0d"},
                                 $time, want.data_byte, want.frame_end, want.status,
                                 want.frame_length, got.data_byte, got.frame_end,
                                 got.status, got.frame_length);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) frame_limit = i_cfg_data;
            if (i_rx.valid && i_rx.ready) decode_byte(i_rx.rx_byte);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_q.size();
        o_checked    <= checked;
        o_frames     <= frames;
    end

endmodule

// ----- tb/escaped_frame_decoder_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the escaped frame decoder: clock, reset, byte stream stimulus,
// limit writes, output back-pressure and the verdict.
// Depends on efd_pkg, the channel interfaces, the block and escaped_frame_decoder_checker.
module escaped_frame_decoder_tb;
    import efd_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int HOLD_CYCLES     = 150;
    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int N_PHASES        = 8;

    // Opening sequence: stray bytes and end outside a frame, empty frame,
    // checksum-only frame, restart mid-frame, literal and escaped escape, bad sum
    localparam logic [7:0] DIRECTED_BYTES [25] = '{
        8'hFF, 8'h00, ESC_BYTE, MARK_END,
        ESC_BYTE, MARK_START, ESC_BYTE, MARK_END,
        ESC_BYTE, MARK_START, 8'h00, ESC_BYTE, MARK_END,
        ESC_BYTE, MARK_START, 8'hAA, ESC_BYTE, MARK_START,
        ESC_BYTE, MARK_LIT, 8'hFF, ESC_BYTE, ESC_BYTE, ESC_BYTE, MARK_END
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;

    efd_rx_if  rx_ch ();
    efd_res_if res_ch ();

    int fail_count;
    int pending;
    int checked;
    int frames;
    int send_idle_pct;
    int recv_stall_pct;
    int sent_count;
    int quiet_cycles;
    bit hold_off_req;

    always #HALF_PERIOD clk = ~clk;

    escaped_frame_decoder u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_rx       (rx_ch),
        .o_res      (res_ch)
    );

    escaped_frame_decoder_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_rx         (rx_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_frames     (frames)
    );

    // Random byte, biased towards the control codes and the extremes
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(5))
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = ESC_BYTE;
                3: b = MARK_START;
                4: b = MARK_LIT;
                default: b = MARK_END;
            endcase
        end
        return b;
    endfunction

    // Offer one item, with random idle cycles first, and wait until it is taken
    task automatic send_item(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        sent_count++;
    endtask

    // Stuff one data byte: the escape goes as literal or escaped escape,
    // ordinary bytes are now and then sent escaped
    task automatic put_data(input logic [7:0] b);
        if (b == ESC_BYTE) begin
            send_item(ESC_BYTE);
            send_item(($urandom_range(1) == 0) ? MARK_LIT : ESC_BYTE);
        end else if (b != MARK_START && b != MARK_LIT && b != MARK_END &&
                     $urandom_range(9) == 0) begin
            send_item(ESC_BYTE);
            send_item(b);
        end else begin
            send_item(b);
        end
    endtask

    // Whole frame: start marker, payload, checksum (optionally corrupted), optional end marker
    task automatic send_frame(input int len, input bit corrupt, input bit close);
        logic [7:0] b;
        logic [7:0] sum;
        sum = 8'h00;
        send_item(ESC_BYTE);
        send_item(MARK_START);
        for (int i = 0; i < len; i++) begin
            b = pick_byte();
            sum = sum + b;
            put_data(b);
        end
        if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
        put_data(sum);
        if (close) begin
            send_item(ESC_BYTE);
            send_item(MARK_END);
        end
    endtask

    // Limit write once everything is out and the pipeline has emptied
    task automatic write_limit(input logic [15:0] v);
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, or one long hold-off on request
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req <= 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles without any accepted item
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Stimulus
    initial begin
        int start;
        logic [15:0] lim;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_data      <= 16'd0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        hold_off_req  <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sent_count     = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_BYTES[i]) send_item(DIRECTED_BYTES[i]);

        // Output held off while a frame longer than the reset limit streams in
        hold_off_req <= 1'b1;
        send_frame(258, 1'b0, 1'b1);

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: lim = 16'd1;
                1: lim = 16'd2;
                2: lim = 16'hFFFF;
                3: lim = 16'd3;
                4: lim = MAX_FRAME_RST;
                5: lim = 16'd17;
                6: lim = 16'hFFFF;
                default: lim = 16'($urandom_range(4, 64));
            endcase
            write_limit(lim);
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct  = 62;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 62;
                end
                default: begin
                    send_idle_pct  = 27;
                    recv_stall_pct <= 27;
                end
            endcase
            start = sent_count;
            while (sent_count - start < ITEMS_PER_PHASE) begin
                case ($urandom_range(9))
                    0: repeat ($urandom_range(1, 4)) send_item(pick_byte());
                    1: send_frame($urandom_range(0, 6), 1'b0, 1'b0);
                    2: begin
                        send_item(ESC_BYTE);
                        send_item(MARK_END);
                    end
                    default: send_frame(($urandom_range(9) == 0) ? $urandom_range(9, 40)
                                                                 : $urandom_range(0, 8),
                                        $urandom_range(3) == 0, 1'b1);
                endcase
            end
        end

        // Drain and let the pipeline settle
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        $display("Run covered %0d input bytes over %0d limit settings and a %0d-cycle hold-off.",
                 sent_count, N_PHASES + 1, HOLD_CYCLES);
        $display("%0d result items checked, %0d of them end-of-frame reports.",
                 checked, frames);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- escaped_frame_decoder.f -----
src/efd_pkg.sv
src/efd_rx_if.sv
src/efd_res_if.sv
src/efd_in_stage.sv
src/efd_decode.sv
src/efd_out_stage.sv
src/escaped_frame_decoder.sv
tb/escaped_frame_decoder_checker.sv
tb/escaped_frame_decoder_tb.sv
